// ===== src/pedal_tilt_axis_conditioner_core_assert.svh =====
// Assertion macros for the pedal/tilt conditioner.
// Included by the top level; no other dependencies.
`ifndef PEDAL_TILT_AXIS_CONDITIONER_CORE_ASSERT_SVH
`define PEDAL_TILT_AXIS_CONDITIONER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PTAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptac: same-cycle check failed");
`define PTAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptac: next-cycle check failed");
`else
`define PTAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ptac_pkg.sv =====
// Shared types and constants of the pedal/tilt conditioner.
// No dependencies.
package ptac_pkg;

    localparam int PEDAL_W    = 12;
    localparam int ACCEL_W    = 16;
    localparam int RANGE_W    = 15;
    localparam int LEVEL_W    = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 15;
    localparam int DIV_Q_W   = 8;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MID = 8'd127;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;
    localparam logic [LEVEL_W-1:0] BRAKE_HAPTIC_LEVEL = 8'd50;
    localparam logic signed [ACCEL_W-1:0] SHOCK_LIMIT = 16'sd4500;

    typedef enum logic [2:0] {
        REG_BRAKE_MIN     = 3'd0,
        REG_BRAKE_MAX     = 3'd1,
        REG_THROTTLE_MIN  = 3'd2,
        REG_THROTTLE_MAX  = 3'd3,
        REG_TILT_X_CENTER = 3'd4,
        REG_TILT_X_RANGE  = 3'd5,
        REG_TILT_Y_CENTER = 3'd6,
        REG_TILT_Y_RANGE  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PEDAL_W-1:0]        brake_min;
        logic [PEDAL_W-1:0]        brake_max;
        logic [PEDAL_W-1:0]        throttle_min;
        logic [PEDAL_W-1:0]        throttle_max;
        logic signed [ACCEL_W-1:0] tilt_x_center;
        logic [RANGE_W-1:0]        tilt_x_range;
        logic signed [ACCEL_W-1:0] tilt_y_center;
        logic [RANGE_W-1:0]        tilt_y_range;
    } t_cfg;

    typedef struct packed {
        logic [PEDAL_W-1:0]        brake_raw;
        logic [PEDAL_W-1:0]        throttle_raw;
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] steer_x;
        logic [LEVEL_W-1:0] steer_y;
        logic [LEVEL_W-1:0] brake_level;
        logic [LEVEL_W-1:0] throttle_level;
        logic               brake_haptic_on;
        logic               shock_haptic_on;
    } t_out;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] q;
    } t_div_rsp;

endpackage

// ===== src/ptac_regs.sv =====
// Configuration register bank with APB-style access.
// Depends on ptac_pkg.
module ptac_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptac_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [ptac_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [ptac_pkg::CFG_DATA_W-1:0]    prdata,
    output ptac_pkg::t_cfg                     o_cfg
);

    ptac_pkg::t_cfg   r_cfg;
    ptac_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx = ptac_pkg::t_reg_idx'(paddr[ptac_pkg::CFG_ADDR_W-1:2]);
    assign w_wr  = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_min     <= 12'd340;
            r_cfg.brake_max     <= 12'd720;
            r_cfg.throttle_min  <= 12'd1150;
            r_cfg.throttle_max  <= 12'd1410;
            r_cfg.tilt_x_center <= 16'sd1850;
            r_cfg.tilt_x_range  <= 15'd200;
            r_cfg.tilt_y_center <= 16'sd840;
            r_cfg.tilt_y_range  <= 15'd200;
        end else if (w_wr) begin
            unique case (w_idx)
                ptac_pkg::REG_BRAKE_MIN:     r_cfg.brake_min     <= pwdata[11:0];
                ptac_pkg::REG_BRAKE_MAX:     r_cfg.brake_max     <= pwdata[11:0];
                ptac_pkg::REG_THROTTLE_MIN:  r_cfg.throttle_min  <= pwdata[11:0];
                ptac_pkg::REG_THROTTLE_MAX:  r_cfg.throttle_max  <= pwdata[11:0];
                ptac_pkg::REG_TILT_X_CENTER: r_cfg.tilt_x_center <= $signed(pwdata[15:0]);
                ptac_pkg::REG_TILT_X_RANGE:  r_cfg.tilt_x_range  <= pwdata[14:0];
                ptac_pkg::REG_TILT_Y_CENTER: r_cfg.tilt_y_center <= $signed(pwdata[15:0]);
                ptac_pkg::REG_TILT_Y_RANGE:  r_cfg.tilt_y_range  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ptac_pkg::REG_BRAKE_MIN:     prdata = {20'd0, r_cfg.brake_min};
            ptac_pkg::REG_BRAKE_MAX:     prdata = {20'd0, r_cfg.brake_max};
            ptac_pkg::REG_THROTTLE_MIN:  prdata = {20'd0, r_cfg.throttle_min};
            ptac_pkg::REG_THROTTLE_MAX:  prdata = {20'd0, r_cfg.throttle_max};
            ptac_pkg::REG_TILT_X_CENTER: prdata = {16'd0, r_cfg.tilt_x_center};
            ptac_pkg::REG_TILT_X_RANGE:  prdata = {17'd0, r_cfg.tilt_x_range};
            ptac_pkg::REG_TILT_Y_CENTER: prdata = {16'd0, r_cfg.tilt_y_center};
            ptac_pkg::REG_TILT_Y_RANGE:  prdata = {17'd0, r_cfg.tilt_y_range};
            default:                     prdata = '0;
        endcase
    end

endmodule

// ===== src/ptac_div.sv =====
// Shared restoring divider, one quotient bit per cycle, quotient saturated at 255.
// Depends on ptac_pkg.
module ptac_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptac_pkg::t_div_req i_req,
    output ptac_pkg::t_div_rsp o_rsp
);

    localparam int HI_W  = ptac_pkg::DIV_NUM_W - ptac_pkg::DIV_Q_W;
    localparam int CNT_W = $clog2(ptac_pkg::DIV_Q_W + 1);

    logic                            r_busy;
    logic                            r_done;
    logic                            r_sat;
    logic [CNT_W-1:0]                r_cnt;
    logic [HI_W-1:0]                 r_rem;
    logic [ptac_pkg::DIV_Q_W-1:0]    r_q;
    logic [ptac_pkg::DIV_DEN_W-1:0]  r_den;
    logic [HI_W-1:0]                 w_trial;
    logic                            w_ge;

    assign w_trial = {r_rem[HI_W-2:0], r_q[ptac_pkg::DIV_Q_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_sat ? ptac_pkg::LEVEL_MAX : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ptac_pkg::DIV_Q_W);
                r_rem  <= i_req.num[ptac_pkg::DIV_NUM_W-1:ptac_pkg::DIV_Q_W];
                r_q    <= i_req.num[ptac_pkg::DIV_Q_W-1:0];
                r_den  <= i_req.den;
                r_sat  <= i_req.num[ptac_pkg::DIV_NUM_W-1:ptac_pkg::DIV_Q_W]
                          >= {1'b0, i_req.den};
            end else if (r_busy) begin
                r_rem <= w_ge ? w_trial - {1'b0, r_den} : w_trial;
                r_q   <= {r_q[ptac_pkg::DIV_Q_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/ptac_seq.sv =====
// Sequencer: operand setup for the four divisions, shared smoothing multiplier,
// accumulators and result register. Depends on ptac_pkg.
module ptac_seq #(
    parameter int ADC_BITS         = 12,
    parameter int SMOOTH_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptac_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptac_pkg::t_in      i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ptac_pkg::t_out     o_out_data,
    output ptac_pkg::t_div_req o_div_req,
    input  ptac_pkg::t_div_rsp i_div_rsp
);

    localparam int F      = SMOOTH_FRAC_BITS;
    localparam int ACC_W  = ptac_pkg::LEVEL_W + F;
    localparam int DIFF_W = ACC_W + 1;
    localparam int PROD_W = DIFF_W + F + 1;
    localparam logic [F-1:0] SMOOTH_FACTOR = F'(((64'd1 << F) * 64'd2 + 64'd5) / 64'd10);
    localparam logic [ptac_pkg::PEDAL_W-1:0] ADC_MASK =
        (ADC_BITS >= ptac_pkg::PEDAL_W) ? '1 : ptac_pkg::PEDAL_W'((1 << ADC_BITS) - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_WAIT, S_MUL, S_ACC, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_BRAKE, OP_THROTTLE, OP_TILT_X, OP_TILT_Y
    } t_op;

    t_state                       r_state;
    t_op                          r_op;
    logic                         r_axis;
    ptac_pkg::t_in                r_in;
    logic [ptac_pkg::LEVEL_W-1:0] r_lvl [4];
    logic                         r_special;
    logic [ptac_pkg::LEVEL_W-1:0] r_special_val;
    logic                         r_neg;
    logic [ACC_W-1:0]             r_acc_x;
    logic [ACC_W-1:0]             r_acc_y;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_out_valid;
    ptac_pkg::t_out               r_out;

    // operand setup
    logic [ptac_pkg::PEDAL_W-1:0]        w_raw, w_mn, w_mx;
    logic signed [ptac_pkg::PEDAL_W:0]   w_dr, w_dm;
    logic [ptac_pkg::PEDAL_W-1:0]        w_abs_dr, w_abs_dm;
    logic [ptac_pkg::PEDAL_W+7:0]        w_pedal_num;
    logic signed [ptac_pkg::ACCEL_W-1:0] w_a, w_c;
    logic [ptac_pkg::RANGE_W-1:0]        w_rng;
    logic signed [ptac_pkg::ACCEL_W:0]   w_d;
    logic signed [ptac_pkg::ACCEL_W+1:0] w_t;
    logic [ptac_pkg::DIV_NUM_W-1:0]      w_tilt_num;
    logic                                w_is_tilt;
    logic                                w_special;
    logic [ptac_pkg::LEVEL_W-1:0]        w_special_val;
    logic                                w_neg;
    logic [ptac_pkg::LEVEL_W-1:0]        w_lvl;

    // smoothing
    logic [ACC_W-1:0]          w_acc;
    logic [ptac_pkg::LEVEL_W-1:0] w_raw_lvl;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [PROD_W-1:0]  w_sum;
    logic [ACC_W-1:0]          w_acc_next;
    logic                      w_shock;

    assign w_is_tilt = r_op[1];

    always_comb begin
        w_raw = (r_op[0] ? r_in.throttle_raw : r_in.brake_raw) & ADC_MASK;
        w_mn  = (r_op[0] ? i_cfg.throttle_min : i_cfg.brake_min) & ADC_MASK;
        w_mx  = (r_op[0] ? i_cfg.throttle_max : i_cfg.brake_max) & ADC_MASK;
        w_dr  = $signed({1'b0, w_raw}) - $signed({1'b0, w_mx});
        w_dm  = $signed({1'b0, w_mn}) - $signed({1'b0, w_mx});
        w_abs_dr = w_dr[ptac_pkg::PEDAL_W] ? ptac_pkg::PEDAL_W'(-w_dr)
                                           : w_dr[ptac_pkg::PEDAL_W-1:0];
        w_abs_dm = w_dm[ptac_pkg::PEDAL_W] ? ptac_pkg::PEDAL_W'(-w_dm)
                                           : w_dm[ptac_pkg::PEDAL_W-1:0];
        w_pedal_num = {w_abs_dr, 8'd0} - {8'd0, w_abs_dr};

        w_a   = r_op[0] ? r_in.accel_y : r_in.accel_x;
        w_c   = r_op[0] ? i_cfg.tilt_y_center : i_cfg.tilt_x_center;
        w_rng = r_op[0] ? i_cfg.tilt_y_range : i_cfg.tilt_x_range;
        w_d   = $signed({w_a[ptac_pkg::ACCEL_W-1], w_a})
              - $signed({w_c[ptac_pkg::ACCEL_W-1], w_c});
        w_t   = $signed({w_d[ptac_pkg::ACCEL_W], w_d}) + $signed({3'd0, w_rng});
        w_tilt_num = {w_t[ptac_pkg::ACCEL_W:0], 7'd0}
                   - {7'd0, w_t[ptac_pkg::ACCEL_W:0]};

        if (w_is_tilt) begin
            w_special = (w_rng == '0);
            if (w_d == '0) begin
                w_special_val = ptac_pkg::LEVEL_MID;
            end else if (w_d[ptac_pkg::ACCEL_W]) begin
                w_special_val = ptac_pkg::LEVEL_MIN;
            end else begin
                w_special_val = ptac_pkg::LEVEL_MAX;
            end
            w_neg = w_t[ptac_pkg::ACCEL_W+1];
        end else begin
            w_special     = (w_dm == '0);
            w_special_val = ptac_pkg::LEVEL_MIN;
            w_neg         = w_dr[ptac_pkg::PEDAL_W] ^ w_dm[ptac_pkg::PEDAL_W];
        end
    end

    assign o_div_req.start = (r_state == S_LOAD);
    assign o_div_req.num   = w_is_tilt ? w_tilt_num
                           : {{(ptac_pkg::DIV_NUM_W - ptac_pkg::PEDAL_W - 8){1'b0}},
                              w_pedal_num};
    assign o_div_req.den   = w_is_tilt ? w_rng
                           : {{(ptac_pkg::DIV_DEN_W - ptac_pkg::PEDAL_W){1'b0}}, w_abs_dm};

    always_comb begin
        priority if (r_special) begin
            w_lvl = r_special_val;
        end else if (r_neg) begin
            w_lvl = ptac_pkg::LEVEL_MIN;
        end else begin
            w_lvl = i_div_rsp.q;
        end
    end

    assign w_acc     = r_axis ? r_acc_y : r_acc_x;
    assign w_raw_lvl = r_axis ? r_lvl[OP_TILT_Y] : r_lvl[OP_TILT_X];
    assign w_diff    = $signed({1'b0, w_raw_lvl, {F{1'b0}}}) - $signed({1'b0, w_acc});
    assign w_sum     = $signed({{(PROD_W-ACC_W){1'b0}}, w_acc}) + (r_prod >>> F);
    assign w_acc_next = w_sum[PROD_W-1] ? '0 : w_sum[ACC_W-1:0];

    assign w_shock = (r_in.accel_x > ptac_pkg::SHOCK_LIMIT)
                  || (r_in.accel_x < -ptac_pkg::SHOCK_LIMIT)
                  || (r_in.accel_y > ptac_pkg::SHOCK_LIMIT)
                  || (r_in.accel_y < -ptac_pkg::SHOCK_LIMIT);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_BRAKE;
            r_axis      <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_op    <= OP_BRAKE;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_special     <= w_special;
                    r_special_val <= w_special_val;
                    r_neg         <= w_neg;
                    r_state       <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_lvl[r_op] <= w_lvl;
                        if (r_op == OP_TILT_Y) begin
                            r_axis  <= 1'b0;
                            r_state <= S_MUL;
                        end else begin
                            r_op    <= t_op'(r_op + 2'd1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= w_diff * $signed({1'b0, SMOOTH_FACTOR});
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_axis) begin
                        r_acc_y <= w_acc_next;
                        r_state <= S_DONE;
                    end else begin
                        r_acc_x <= w_acc_next;
                        r_axis  <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.steer_x         <= r_acc_x[ACC_W-1:F];
                        r_out.steer_y         <= r_acc_y[ACC_W-1:F];
                        r_out.brake_level     <= r_lvl[OP_BRAKE];
                        r_out.throttle_level  <= r_lvl[OP_THROTTLE];
                        r_out.brake_haptic_on <= r_lvl[OP_BRAKE] > ptac_pkg::BRAKE_HAPTIC_LEVEL;
                        r_out.shock_haptic_on <= w_shock;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/pedal_tilt_axis_conditioner_core.sv =====
// Top level of the pedal/tilt conditioner: register bank, sequencer, shared divider.
// Depends on ptac_pkg, ptac_regs, ptac_div, ptac_seq and the assertion header.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_in_data  (ptac_pkg::t_in)
//  result    out        o_out_valid / i_out_ready  o_out_data (ptac_pkg::t_out)
//  config    in         psel / penable / pready    paddr, pwdata, prdata
//
// A new sample is accepted only while the sequencer is idle. It then runs four
// divisions in turn on the shared 8-step divider, smooths both tilt axes on the
// shared multiplier and loads the result register, before it returns to idle.
// A result waits in the output register while the next transfer is computed;
// the final load stalls until that register is free. Reset is synchronous.
`include "pedal_tilt_axis_conditioner_core_assert.svh"

module pedal_tilt_axis_conditioner_core #(
    parameter int ADC_BITS         = 12,
    parameter int SMOOTH_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ptac_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ptac_pkg::t_out                   o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptac_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ptac_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ptac_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);

    ptac_pkg::t_cfg     w_cfg;
    ptac_pkg::t_div_req w_div_req;
    ptac_pkg::t_div_rsp w_div_rsp;

    assign pready = 1'b1;

    ptac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    ptac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    ptac_seq #(
        .ADC_BITS         (ADC_BITS),
        .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp)
    );

    `PTAC_ASSERT_IMP(a_start_when_busy, i_clk, i_rst_n, w_div_req.start, !o_in_ready)
    `PTAC_ASSERT_IMP(a_done_not_start, i_clk, i_rst_n, w_div_rsp.done, !w_div_req.start)
    `PTAC_ASSERT_NEXT(a_start_no_done, i_clk, i_rst_n, w_div_req.start, !w_div_rsp.done)
    `PTAC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

// ===== verif/pedal_tilt_axis_conditioner_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pedal_tilt_axis_conditioner_core: directed table, then random phases.
// Depends on ptac_pkg and the core; predicts or looks up each transfer's result, compares in order.
module pedal_tilt_axis_conditioner_core_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_PAD     = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 315;
    localparam int SMOOTH_FRAC   = 16;
    localparam longint SMOOTH_GAIN = ((64'd1 << SMOOTH_FRAC) * 2 + 5) / 10;

    typedef struct {
        int             cfg_sel;
        ptac_pkg::t_in  sample;
        bit             typed;
        ptac_pkg::t_out want;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    ptac_pkg::t_in                   i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    ptac_pkg::t_out                  o_out_data;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [ptac_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [ptac_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [ptac_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    ptac_pkg::t_cfg  cal;
    logic [23:0]     smooth_x;
    logic [23:0]     smooth_y;
    ptac_pkg::t_out  expected_q [$];
    ptac_pkg::t_out  want_now;
    int              mismatches = 0;
    int              results_seen = 0;
    int              cycle_count = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    bit              hold_req = 1'b0;
    int              hold_left = 0;

    ptac_pkg::t_cfg cfg_presets [3] = '{
        '{12'd340, 12'd720, 12'd1150, 12'd1410, 16'sd1850, 15'd200, 16'sd840, 15'd200},
        '{12'd2000, 12'd2000, 12'd4095, 12'd0, 16'sd0, 15'd0, 16'sh8000, 15'd32767},
        '{12'd0, 12'd4095, 12'd0, 12'd0, 16'sd32767, 15'd1, 16'sh8000, 15'd0}
    };

    t_dir_row dir_rows [17] = '{
        '{0, '{12'd720, 12'd1410, 16'sd1850, 16'sd840}, 1'b1,
            '{8'd25, 8'd25, 8'd0, 8'd0, 1'b0, 1'b0}},
        '{0, '{12'd340, 12'd1150, 16'sd1850, 16'sd840}, 1'b0, '0},
        '{0, '{12'd0, 12'd0, 16'sh8000, 16'sh8000}, 1'b0, '0},
        '{0, '{12'd4095, 12'd4095, 16'sd32767, 16'sd32767}, 1'b0, '0},
        '{0, '{12'd645, 12'd1280, 16'sd4500, -16'sd4500}, 1'b0, '0},
        '{0, '{12'd644, 12'd1280, 16'sd4501, 16'sd0}, 1'b0, '0},
        '{0, '{12'd500, 12'd1200, 16'sd0, -16'sd4501}, 1'b0, '0},
        '{0, '{12'd720, 12'd1410, 16'sd1650, 16'sd1040}, 1'b0, '0},
        '{0, '{12'd720, 12'd1410, 16'sd1849, 16'sd841}, 1'b0, '0},
        '{0, '{12'd721, 12'd1409, 16'sd2050, 16'sd640}, 1'b0, '0},
        '{1, '{12'd2000, 12'd0, 16'sd1, 16'sh8000}, 1'b0, '0},
        '{1, '{12'd0, 12'd4095, -16'sd1, 16'sd32767}, 1'b0, '0},
        '{1, '{12'd4095, 12'd2048, 16'sd0, 16'sd0}, 1'b0, '0},
        '{2, '{12'd4095, 12'd4095, 16'sd32767, 16'sh8000}, 1'b0, '0},
        '{2, '{12'd0, 12'd0, 16'sh8000, 16'sd32767}, 1'b0, '0},
        '{2, '{12'd2047, 12'd1, 16'sd32766, -16'sd32767}, 1'b0, '0},
        '{2, '{12'd1, 12'd2048, -16'sd1, 16'sd1}, 1'b0, '0}
    };

    pedal_tilt_axis_conditioner_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [ptac_pkg::LEVEL_W-1:0] clamp_level(longint v);
        if (v < 0) return ptac_pkg::LEVEL_MIN;
        if (v > 255) return ptac_pkg::LEVEL_MAX;
        return v[ptac_pkg::LEVEL_W-1:0];
    endfunction

    function automatic logic [ptac_pkg::LEVEL_W-1:0] pedal_level(
            logic [ptac_pkg::PEDAL_W-1:0] raw,
            logic [ptac_pkg::PEDAL_W-1:0] lo,
            logic [ptac_pkg::PEDAL_W-1:0] hi);
        longint r, mn, mx;
        r = raw;
        mn = lo;
        mx = hi;
        if (mn == mx) return ptac_pkg::LEVEL_MIN;
        return clamp_level((r - mx) * 255 / (mn - mx));
    endfunction

    function automatic longint tilt_level(logic signed [ptac_pkg::ACCEL_W-1:0] a,
                                         logic signed [ptac_pkg::ACCEL_W-1:0] center,
                                         logic [ptac_pkg::RANGE_W-1:0] range);
        longint av, cv, d, r, num, q;
        av = a;
        cv = center;
        d = av - cv;
        r = range;
        if (r == 0) return (d > 0) ? 255 : ((d < 0) ? 0 : 127);
        num = d * 127 + 127 * r;
        q = num / r;
        if (num % r != 0 && num < 0) q--;
        return clamp_level(q);
    endfunction

    function automatic logic [23:0] smooth_step(logic [23:0] acc, longint lvl);
        longint a, p;
        a = acc;
        p = ((lvl <<< SMOOTH_FRAC) - a) * SMOOTH_GAIN;
        a = a + (p >>> SMOOTH_FRAC);
        if (a < 0) a = 0;
        return a[23:0];
    endfunction

    function automatic longint magnitude(logic signed [ptac_pkg::ACCEL_W-1:0] a);
        longint v;
        v = a;
        return (v < 0) ? -v : v;
    endfunction

    function automatic ptac_pkg::t_out predict_sample(ptac_pkg::t_in s);
        ptac_pkg::t_out o;
        o.brake_level = pedal_level(s.brake_raw, cal.brake_min, cal.brake_max);
        o.throttle_level = pedal_level(s.throttle_raw, cal.throttle_min, cal.throttle_max);
        smooth_x = smooth_step(smooth_x, tilt_level(s.accel_x, cal.tilt_x_center,
                                                    cal.tilt_x_range));
        smooth_y = smooth_step(smooth_y, tilt_level(s.accel_y, cal.tilt_y_center,
                                                    cal.tilt_y_range));
        o.steer_x = smooth_x[23:16];
        o.steer_y = smooth_y[23:16];
        o.brake_haptic_on = longint'(o.brake_level) > longint'(ptac_pkg::BRAKE_HAPTIC_LEVEL);
        o.shock_haptic_on = magnitude(s.accel_x) > longint'(ptac_pkg::SHOCK_LIMIT)
                         || magnitude(s.accel_y) > longint'(ptac_pkg::SHOCK_LIMIT);
        return o;
    endfunction

    function automatic logic signed [ptac_pkg::ACCEL_W-1:0] clamp_accel(longint v);
        if (v < -32768) return 16'sh8000;
        if (v > 32767) return 16'sh7fff;
        return v[ptac_pkg::ACCEL_W-1:0];
    endfunction

    function automatic logic [ptac_pkg::RANGE_W-1:0] random_range();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return ptac_pkg::RANGE_W'($urandom_range(32767, 1));
        return ptac_pkg::RANGE_W'($urandom_range(3000, 1));
    endfunction

    function automatic ptac_pkg::t_cfg random_cfg();
        ptac_pkg::t_cfg c;
        c.brake_min = ptac_pkg::PEDAL_W'($urandom());
        c.brake_max = ($urandom_range(7) == 0) ? c.brake_min
                                               : ptac_pkg::PEDAL_W'($urandom());
        c.throttle_min = ptac_pkg::PEDAL_W'($urandom());
        c.throttle_max = ($urandom_range(7) == 0) ? c.throttle_min
                                                  : ptac_pkg::PEDAL_W'($urandom());
        c.tilt_x_center = ($urandom_range(3) == 0)
                        ? ptac_pkg::ACCEL_W'($urandom())
                        : clamp_accel(longint'(int'($urandom_range(16000)) - 8000));
        c.tilt_y_center = ($urandom_range(3) == 0)
                        ? ptac_pkg::ACCEL_W'($urandom())
                        : clamp_accel(longint'(int'($urandom_range(16000)) - 8000));
        c.tilt_x_range = random_range();
        c.tilt_y_range = random_range();
        return c;
    endfunction

    function automatic logic [ptac_pkg::PEDAL_W-1:0] pedal_near(
            logic [ptac_pkg::PEDAL_W-1:0] a,
            logic [ptac_pkg::PEDAL_W-1:0] b);
        int lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        lo = (lo > 40) ? lo - 40 : 0;
        hi = (hi < 4055) ? hi + 40 : 4095;
        return ptac_pkg::PEDAL_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic signed [ptac_pkg::ACCEL_W-1:0] accel_near(
            logic signed [ptac_pkg::ACCEL_W-1:0] c,
            logic [ptac_pkg::RANGE_W-1:0] r);
        longint span, base;
        span = longint'(r) + longint'(r) / 2 + 8;
        base = c;
        return clamp_accel(base + longint'($urandom_range(2 * span)) - span);
    endfunction

    function automatic ptac_pkg::t_in random_sample();
        ptac_pkg::t_in s;
        int mode;
        mode = $urandom_range(9);
        if (mode < 6) begin
            s.brake_raw = pedal_near(cal.brake_min, cal.brake_max);
            s.throttle_raw = pedal_near(cal.throttle_min, cal.throttle_max);
            s.accel_x = accel_near(cal.tilt_x_center, cal.tilt_x_range);
            s.accel_y = accel_near(cal.tilt_y_center, cal.tilt_y_range);
        end else if (mode < 7) begin
            s.brake_raw = pedal_near(cal.brake_min, cal.brake_max);
            s.throttle_raw = pedal_near(cal.throttle_min, cal.throttle_max);
            s.accel_x = clamp_accel(($urandom_range(1) ? 4500 : -4500)
                                    + longint'($urandom_range(4)) - 2);
            s.accel_y = clamp_accel(($urandom_range(1) ? 4500 : -4500)
                                    + longint'($urandom_range(4)) - 2);
        end else begin
            s.brake_raw = ptac_pkg::PEDAL_W'($urandom());
            s.throttle_raw = ptac_pkg::PEDAL_W'($urandom());
            s.accel_x = ptac_pkg::ACCEL_W'($urandom());
            s.accel_y = ptac_pkg::ACCEL_W'($urandom());
        end
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic write_cfg(input ptac_pkg::t_cfg c, input bit noisy);
        logic [ptac_pkg::CFG_DATA_W-1:0] upper;
        logic [ptac_pkg::CFG_DATA_W-1:0] word;
        ptac_pkg::t_reg_idx idx;
        int k;
        for (k = 0; k < 8; k++) begin
            idx = ptac_pkg::t_reg_idx'(k);
            upper = noisy ? $urandom() : '0;
            unique case (idx)
                ptac_pkg::REG_BRAKE_MIN:     word = {upper[31:12], c.brake_min};
                ptac_pkg::REG_BRAKE_MAX:     word = {upper[31:12], c.brake_max};
                ptac_pkg::REG_THROTTLE_MIN:  word = {upper[31:12], c.throttle_min};
                ptac_pkg::REG_THROTTLE_MAX:  word = {upper[31:12], c.throttle_max};
                ptac_pkg::REG_TILT_X_CENTER: word = {upper[31:16], c.tilt_x_center};
                ptac_pkg::REG_TILT_X_RANGE:  word = {upper[31:15], c.tilt_x_range};
                ptac_pkg::REG_TILT_Y_CENTER: word = {upper[31:16], c.tilt_y_center};
                ptac_pkg::REG_TILT_Y_RANGE:  word = {upper[31:15], c.tilt_y_range};
            endcase
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= word;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cal = c;
    endtask

    task automatic wait_drained(input int pad);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    task automatic drive_sample(input ptac_pkg::t_in s, input bit typed,
                                input ptac_pkg::t_out want);
        int gap;
        ptac_pkg::t_out pred;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_sample(s);
        expected_q.push_back(typed ? want : pred);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("transfer with nothing expected", 0, 0);
            end else begin
                want_now = expected_q.pop_front();
                if (o_out_data.steer_x !== want_now.steer_x)
                    report_mismatch("steer_x", o_out_data.steer_x, want_now.steer_x);
                if (o_out_data.steer_y !== want_now.steer_y)
                    report_mismatch("steer_y", o_out_data.steer_y, want_now.steer_y);
                if (o_out_data.brake_level !== want_now.brake_level)
                    report_mismatch("brake_level", o_out_data.brake_level,
                                    want_now.brake_level);
                if (o_out_data.throttle_level !== want_now.throttle_level)
                    report_mismatch("throttle_level", o_out_data.throttle_level,
                                    want_now.throttle_level);
                if (o_out_data.brake_haptic_on !== want_now.brake_haptic_on)
                    report_mismatch("brake_haptic_on", o_out_data.brake_haptic_on,
                                    want_now.brake_haptic_on);
                if (o_out_data.shock_haptic_on !== want_now.shock_haptic_on)
                    report_mismatch("shock_haptic_on", o_out_data.shock_haptic_on,
                                    want_now.shock_haptic_on);
            end
            results_seen++;
        end
    end

    initial begin
        int cur_sel;
        int p;
        int k;
        cal = cfg_presets[0];
        smooth_x = '0;
        smooth_y = '0;
        cur_sel = 0;
        send_idle_pct = 23;
        recv_idle_pct = 45;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_sel != cur_sel) begin
                wait_drained(DRAIN_PAD);
                write_cfg(cfg_presets[dir_rows[r].cfg_sel], 1'b0);
                cur_sel = dir_rows[r].cfg_sel;
            end
            drive_sample(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].want);
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained(DRAIN_PAD);
            write_cfg(random_cfg(), p[0]);
            send_idle_pct = (p < 2) ? 23 : ((p < 4) ? 45 : 0);
            recv_idle_pct = (p < 2) ? 45 : ((p < 4) ? 23 : 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 1 && k == 100) hold_req = 1'b1;
                if (p == 3 && k == 150) wait_drained(0);
                drive_sample(random_sample(), 1'b0, '0);
            end
        end

        wait_drained(DRAIN_PAD);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ptac_pkg.sv
src/ptac_regs.sv
src/ptac_div.sv
src/ptac_seq.sv
src/pedal_tilt_axis_conditioner_core.sv
verif/pedal_tilt_axis_conditioner_core_tb.sv
